[rtl/core/xbe_pkg.sv]
package xbe_pkg;

  typedef logic [31:0] word_t;
  typedef logic [3:0][31:0] key_t;

  // one block in flight: both halves and the running sum
  typedef struct packed {
    word_t a;
    word_t b;
    word_t sum;
  } blk_t;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_KEY0  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY1  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY2  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY3  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DELTA = 3'd4;

  localparam word_t DeltaReset = 32'h9E3779B9;

  function automatic word_t xtea_mix(word_t v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

[rtl/core/xbe_cfg_regs.sv]
module xbe_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [xbe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                cfg_data_i,
  output xbe_pkg::key_t              key_o,
  output xbe_pkg::word_t             delta_o
);
  import xbe_pkg::*;

  key_t  key_q;
  word_t delta_q;
  logic  wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      delta_q <= DeltaReset;
    end else if (wr_en) begin
      case (cfg_index_i)
        REG_KEY0:  key_q[0] <= cfg_data_i;
        REG_KEY1:  key_q[1] <= cfg_data_i;
        REG_KEY2:  key_q[2] <= cfg_data_i;
        REG_KEY3:  key_q[3] <= cfg_data_i;
        REG_DELTA: delta_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign key_o   = key_q;
  assign delta_o = delta_q;

endmodule

[rtl/core/xbe_half_stage.sv]
module xbe_half_stage #(
  parameter bit SECOND_HALF = 1'b0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  xbe_pkg::blk_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output xbe_pkg::blk_t  data_o,
  input  xbe_pkg::key_t  key_i,
  input  xbe_pkg::word_t delta_i
);
  import xbe_pkg::*;

  logic  valid_q;
  blk_t  data_q;
  blk_t  data_d;
  word_t key_sel;
  word_t mix_val;

  always_comb begin
    data_d = data_i;
    if (SECOND_HALF) begin
      // sum was already advanced by the first half of this round
      key_sel  = key_i[data_i.sum[12:11]];
      mix_val  = xtea_mix(data_i.a);
      data_d.b = data_i.b + (mix_val ^ (data_i.sum + key_sel));
    end else begin
      key_sel    = key_i[data_i.sum[1:0]];
      mix_val    = xtea_mix(data_i.b);
      data_d.a   = data_i.a + (mix_val ^ (data_i.sum + key_sel));
      data_d.sum = data_i.sum + delta_i;
    end
  end

  // a bubble in this stage lets the upstream side move on
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/core/xtea_block_encrypt.sv]
// xtea block encryption, one 64-bit block per word, electronic codebook
//
// input stream s_axis: tdata carries plain_first in bits 31:0 and
// plain_second in bits 63:32. output stream m_axis: tdata carries
// cipher_first in bits 31:0 and cipher_second in bits 63:32.
// config channel cfg: index 0..3 writes key words 0..3, index 4 writes
// the round delta; other indexes are dropped. cfg_ready_o is always high.
// write config only while no block is in flight.
//
// one register stage per half round. throughput is one block per cycle
// while m_axis_tready stays high; a low m_axis_tready stalls the pipeline.
// each stage holds its word until the next stage takes it, so a stalled
// receiver fills the pipeline from the back and empty stages keep taking
// input; nothing is lost or repeated.
// reset clears all stage valid bits, key words to zero and the delta
// to 0x9E3779B9.
module xtea_block_encrypt #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,   // plain_first, plain_second
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [63:0]                 m_axis_tdata,   // cipher_first, cipher_second
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [xbe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);
  import xbe_pkg::*;

  localparam int unsigned NStage = 2 * ROUNDS;

  key_t  key;
  word_t delta;

  logic stg_valid [NStage+1];
  logic stg_ready [NStage+1];
  blk_t stg_data  [NStage+1];

  xbe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .key_o       (key),
    .delta_o     (delta)
  );

  assign stg_valid[0]    = s_axis_tvalid;
  assign s_axis_tready   = stg_ready[0];
  assign stg_data[0].a   = s_axis_tdata[31:0];
  assign stg_data[0].b   = s_axis_tdata[63:32];
  assign stg_data[0].sum = '0;

  for (genvar k = 0; k < NStage; k++) begin : g_stage
    xbe_half_stage #(
      .SECOND_HALF ((k % 2) == 1)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k]),
      .ready_o (stg_ready[k]),
      .data_i  (stg_data[k]),
      .valid_o (stg_valid[k+1]),
      .ready_i (stg_ready[k+1]),
      .data_o  (stg_data[k+1]),
      .key_i   (key),
      .delta_i (delta)
    );
  end

  assign stg_ready[NStage] = m_axis_tready;
  assign m_axis_tvalid     = stg_valid[NStage];
  assign m_axis_tdata      = {stg_data[NStage].b, stg_data[NStage].a};

endmodule
